@@ design/cfa_pkg.sv @@
// Package for the contiguous fit allocator: result kinds, policy codes,
// register indexes and function codes. No dependencies.
package cfa_pkg;

    localparam logic [1:0] KIND_LOADED   = 2'd0;
    localparam logic [1:0] KIND_EVICTED  = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;
    localparam logic [1:0] KIND_CLEARED  = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic [0:0] REG_POLICY = 1'd0;
    localparam logic [0:0] REG_LIMIT  = 1'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

endpackage

@@ design/cfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ design/contiguous_fit_allocator.sv @@
// Contiguous fit allocator over a bitmap of MEM_UNITS units. One sequencer walks the
// map one unit per cycle: a fit scan walks the map once (twice round under next fit),
// each eviction reads the oldest resident entry, frees its run and retries the scan, and
// every load places its run one unit per cycle and ends with a statistics walk over the
// map. A clear sweeps the map. The input is not ready while an item is at work or a
// result transfer waits; results leave through an output register. Depends on cfa_pkg
// and cfa_ram.
module contiguous_fit_allocator #(
    parameter int MEM_UNITS      = 128,
    parameter int RESIDENT_SLOTS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_proc_id,
    input  logic [7:0] s_req_size,
    input  logic [3:0] s_swap_count,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_id,
    output logic [6:0] m_base_unit,
    output logic [3:0] m_new_swaps,
    output logic       m_requeue,
    output logic [5:0] m_resident_count,
    output logic [6:0] m_hole_count,
    output logic [7:0] m_used_units,
    output logic       m_last
);
    localparam int UW = $clog2(MEM_UNITS);
    localparam int CW = $clog2(MEM_UNITS + 1);
    localparam int SW = $clog2(RESIDENT_SLOTS);
    localparam int FW = $clog2(RESIDENT_SLOTS + 1);
    localparam int EW = 8 + UW + CW + 4;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_RDQ    = 4'd3;
    localparam logic [3:0] ST_RDW    = 4'd4;
    localparam logic [3:0] ST_FREE   = 4'd5;
    localparam logic [3:0] ST_SCAN   = 4'd6;
    localparam logic [3:0] ST_PLACE  = 4'd7;
    localparam logic [3:0] ST_STATS  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_EVOUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] policy_reg;
    logic [3:0] limit_reg;
    logic [MEM_UNITS-1:0] busy_reg;
    logic [SW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [UW-1:0] nstart_reg;

    logic [7:0] id_reg;
    logic [CW-1:0] size_reg;
    logic [3:0] swaps_reg;
    logic [CW:0] k_reg;
    logic [CW-1:0] run_reg, start_reg, bl_reg;
    logic [UW-1:0] bb_reg;
    logic found_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] holes_reg;
    logic [EW-1:0] ev_reg;

    logic [1:0] o_kind;
    logic [7:0] o_id;
    logic [6:0] o_base;
    logic [3:0] o_ns;
    logic o_rq;
    logic [5:0] o_rc;
    logic [6:0] o_hc;
    logic [7:0] o_used;
    logic o_last;

    logic ram_we;
    logic [SW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    cfa_ram #(.WIDTH(EW), .DEPTH(RESIDENT_SLOTS)) u_fifo (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(head_reg), .rd_data(ram_rdata)
    );

    // Entry fields.
    logic [7:0]    ev_id;
    logic [UW-1:0] ev_base;
    logic [CW-1:0] ev_size;
    logic [3:0]    ev_sw;
    assign {ev_id, ev_base, ev_size, ev_sw} = ev_reg;

    // Scan position for the current step.
    logic [UW-1:0] pos;
    logic at_end;
    logic [CW:0] sum_pos;
    always_comb begin
        sum_pos = (CW+1)'(nstart_reg) + k_reg;
        if (policy_reg == cfa_pkg::POL_NEXT) begin
            if (sum_pos < (CW+1)'(MEM_UNITS)) begin
                pos = UW'(sum_pos);
            end else if (sum_pos < (CW+1)'(2 * MEM_UNITS)) begin
                pos = UW'(sum_pos - (CW+1)'(MEM_UNITS));
            end else begin
                pos = UW'(sum_pos - (CW+1)'(2 * MEM_UNITS));
            end
            at_end = 1'b0;
        end else begin
            pos = UW'(k_reg);
            at_end = (k_reg == (CW+1)'(MEM_UNITS));
        end
    end
    logic unit_free;
    assign unit_free = !at_end && !busy_reg[pos];
    logic [CW-1:0] run_inc;
    assign run_inc = run_reg + 1'b1;

    // A next fit scan step that completes a fitting run.
    logic next_hit;
    assign next_hit = !busy_reg[pos] &&
                      ((pos == '0) ? (size_reg == CW'(1)) : (run_inc >= size_reg));

    logic [3:0] ns_sat;
    assign ns_sat = (ev_sw == 4'd15) ? 4'd15 : ev_sw + 4'd1;

    logic [UW-1:0] place_pos;
    assign place_pos = UW'((CW+1)'(bb_reg) + k_reg);

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    logic out_free;
    assign out_free = !m_valid || m_ready;

    // A result enters the output register in this cycle.
    logic out_load;
    assign out_load = out_free &&
                      ((state_reg == ST_FREE && (CW+1)'(ev_size) == k_reg) ||
                       (state_reg == ST_STATS && k_reg == (CW+1)'(MEM_UNITS)) ||
                       state_reg == ST_OUT);

    logic take;
    always_comb begin
        unique case (policy_reg)
            cfa_pkg::POL_FIRST: take = !found_reg;
            cfa_pkg::POL_BEST:  take = !found_reg || run_reg <= bl_reg;
            default:            take = !found_reg || run_reg > bl_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            policy_reg <= cfa_pkg::POL_FIRST;
            limit_reg <= 4'd3;
            busy_reg <= '0;
            head_reg <= '0;
            fill_reg <= '0;
            nstart_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cfa_pkg::REG_POLICY: policy_reg <= cfg_data[1:0];
                    default:             limit_reg <= cfg_data;
                endcase
            end
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        id_reg <= s_proc_id;
                        size_reg <= CW'(s_req_size);
                        swaps_reg <= s_swap_count;
                        k_reg <= '0;
                        if (s_func == cfa_pkg::FUNC_CLEAR) begin
                            state_reg <= ST_CLEAR;
                        end else if (s_req_size == 8'd0 ||
                                     {1'b0, s_req_size} > 9'(MEM_UNITS)) begin
                            o_kind <= cfa_pkg::KIND_REJECTED;
                            o_id <= s_proc_id;
                            o_base <= '0; o_ns <= '0; o_rq <= 1'b0;
                            o_rc <= '0; o_hc <= '0; o_used <= '0; o_last <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_CLEAR: begin
                    busy_reg[UW'(k_reg)] <= 1'b0;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == (CW+1)'(MEM_UNITS - 1)) begin
                        head_reg <= '0; fill_reg <= '0; nstart_reg <= '0;
                        o_kind <= cfa_pkg::KIND_CLEARED;
                        o_id <= '0; o_base <= '0; o_ns <= '0; o_rq <= 1'b0;
                        o_rc <= '0; o_hc <= '0; o_used <= '0; o_last <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DECIDE: begin
                    k_reg <= '0; run_reg <= '0; found_reg <= 1'b0;
                    bl_reg <= '0; bb_reg <= '0; start_reg <= '0;
                    if (fill_reg >= FW'(RESIDENT_SLOTS)) state_reg <= ST_RDQ;
                    else state_reg <= ST_SCAN;
                end
                ST_RDQ: state_reg <= ST_RDW;
                ST_RDW: begin
                    ev_reg <= ram_rdata;
                    k_reg <= '0;
                    state_reg <= ST_FREE;
                end
                ST_FREE: begin
                    if ((CW+1)'(ev_size) == k_reg) begin
                        if (out_free) begin
                            o_kind <= cfa_pkg::KIND_EVICTED;
                            o_id <= ev_id;
                            o_base <= 7'(ev_base);
                            o_ns <= ns_sat;
                            o_rq <= ns_sat < limit_reg;
                            o_rc <= '0; o_hc <= '0; o_used <= '0; o_last <= 1'b0;
                            head_reg <= (head_reg == SW'(RESIDENT_SLOTS - 1)) ? '0
                                        : head_reg + 1'b1;
                            fill_reg <= fill_reg - 1'b1;
                            k_reg <= '0; run_reg <= '0; found_reg <= 1'b0;
                            bl_reg <= '0; bb_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end else begin
                        if ((CW+1)'(ev_base) + k_reg < (CW+1)'(MEM_UNITS)) begin
                            busy_reg[UW'((CW+1)'(ev_base) + k_reg)] <= 1'b0;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    k_reg <= k_reg + 1'b1;
                    if (policy_reg == cfa_pkg::POL_NEXT) begin
                        if (pos == '0 || busy_reg[pos]) begin
                            run_reg <= busy_reg[pos] ? '0 : CW'(1);
                            if (!busy_reg[pos] && size_reg == CW'(1)) begin
                                bb_reg <= pos; found_reg <= 1'b1;
                                k_reg <= '0; state_reg <= ST_PLACE;
                            end
                        end else begin
                            run_reg <= run_inc;
                            if (run_inc >= size_reg) begin
                                bb_reg <= UW'((CW+1)'(pos) + 1'b1 - (CW+1)'(size_reg));
                                found_reg <= 1'b1;
                                k_reg <= '0; state_reg <= ST_PLACE;
                            end
                        end
                        if (k_reg == (CW+1)'(2 * MEM_UNITS - 1) && !next_hit) begin
                            k_reg <= '0;
                            if (fill_reg == '0) state_reg <= ST_PLACE;
                            else state_reg <= ST_RDQ;
                        end
                    end else if (unit_free) begin
                        if (run_reg == '0) start_reg <= CW'(pos);
                        run_reg <= run_inc;
                    end else begin
                        run_reg <= '0;
                        if (run_reg >= size_reg && take) begin
                            found_reg <= 1'b1;
                            bl_reg <= run_reg;
                            bb_reg <= UW'(start_reg);
                        end
                        if (at_end) begin
                            k_reg <= '0;
                            if (found_reg || (run_reg >= size_reg && take) ||
                                fill_reg == '0) begin
                                state_reg <= ST_PLACE;
                            end else begin
                                state_reg <= ST_RDQ;
                            end
                        end
                    end
                end
                ST_PLACE: begin
                    busy_reg[place_pos] <= 1'b1;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == (CW+1)'(size_reg)) begin
                        k_reg <= '0; used_reg <= '0; holes_reg <= '0;
                        nstart_reg <= UW'((CW+1)'(bb_reg) + (CW+1)'(size_reg));
                        state_reg <= ST_STATS;
                    end
                end
                ST_STATS: begin
                    if (k_reg == (CW+1)'(MEM_UNITS)) begin
                        if (out_free) begin
                            fill_reg <= fill_reg + 1'b1;
                            o_kind <= cfa_pkg::KIND_LOADED;
                            o_id <= id_reg;
                            o_base <= 7'(bb_reg);
                            o_ns <= '0; o_rq <= 1'b0;
                            o_rc <= 6'(fill_reg + 1'b1);
                            o_hc <= 7'(holes_reg);
                            o_used <= 8'(used_reg);
                            o_last <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        if (busy_reg[UW'(k_reg)]) used_reg <= used_reg + 1'b1;
                        else if (k_reg == '0 || busy_reg[UW'(k_reg - 1'b1)])
                            holes_reg <= holes_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Resident entry written when the load's result enters the output register, after the statistics walk.
    logic [SW:0] tail_sum;
    assign tail_sum = (SW+1)'(head_reg) + (SW+1)'(fill_reg);
    assign ram_we = (state_reg == ST_STATS) && (k_reg == (CW+1)'(MEM_UNITS)) && out_free;
    assign ram_waddr = (tail_sum >= (SW+1)'(RESIDENT_SLOTS)) ?
                       SW'(tail_sum - (SW+1)'(RESIDENT_SLOTS)) : SW'(tail_sum);
    assign ram_wdata = {id_reg, bb_reg, size_reg, swaps_reg};

    assign m_kind = o_kind;
    assign m_out_id = o_id;
    assign m_base_unit = o_base;
    assign m_new_swaps = o_ns;
    assign m_requeue = o_rq;
    assign m_resident_count = o_rc;
    assign m_hole_count = o_hc;
    assign m_used_units = o_used;
    assign m_last = o_last;

    ap_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(RESIDENT_SLOTS)) else $error("resident fill overflow");
    ap_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("result dropped");
    ap_last_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == cfa_pkg::KIND_EVICTED |-> !m_last)
        else $error("eviction marked last");
endmodule

@@ verif/contiguous_fit_allocator_test.sv @@
// Self-checking testbench for contiguous_fit_allocator: directed table, then random
// requests under every fit policy with random idling, checked against an in-bench predictor.
// Depends on cfa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module contiguous_fit_allocator_test;

    localparam int UNITS = 128;
    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] id;
        logic [6:0] base;
        logic [3:0] nsw;
        logic       rq;
        logic [5:0] rc;
        logic [6:0] hc;
        logic [7:0] used;
        logic       last;
    } outcome_t;

    typedef struct {
        logic       func;
        logic [7:0] id;
        logic [7:0] size;
        logic [3:0] sw;
        bit         typed;
        logic [1:0] kind;
        logic [6:0] base;
        logic [5:0] rc;
        logic [6:0] hc;
        logic [7:0] used;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = 1'b0;
    logic [7:0] s_proc_id = '0;
    logic [7:0] s_req_size = '0;
    logic [3:0] s_swap_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_out_id;
    logic [6:0] m_base_unit;
    logic [3:0] m_new_swaps;
    logic m_requeue;
    logic [5:0] m_resident_count;
    logic [6:0] m_hole_count;
    logic [7:0] m_used_units;
    logic m_last;

    contiguous_fit_allocator i_dut (.*);

    // Predictor state
    logic [1:0] pol_q = cfa_pkg::POL_FIRST;
    logic [3:0] limit_q = 4'd3;
    bit busy_map [UNITS];
    logic [7:0] res_id [SLOTS];
    int res_base [SLOTS];
    int res_size [SLOTS];
    int res_sw [SLOTS];
    int res_head, res_fill, next_pos;

    outcome_t pending_q[$];
    outcome_t scratch_q[$];
    int errors = 0;
    int cycles = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic outcome_t mk(logic [1:0] kind, logic [7:0] id, int base, int nsw,
                                    bit rq, int rc, int hc, int used, bit last);
        outcome_t o;
        o.kind = kind; o.id = id; o.base = base[6:0]; o.nsw = nsw[3:0]; o.rq = rq;
        o.rc = rc[5:0]; o.hc = hc[6:0]; o.used = used[7:0]; o.last = last;
        return o;
    endfunction

    function automatic void evict_oldest();
        int h, ns;
        h = res_head;
        for (int i = 0; i < res_size[h]; i++)
            if (res_base[h] + i < UNITS) busy_map[res_base[h] + i] = 0;
        ns = (res_sw[h] + 1 > 15) ? 15 : res_sw[h] + 1;
        scratch_q.push_back(mk(cfa_pkg::KIND_EVICTED, res_id[h], res_base[h], ns,
                               ns < limit_q, 0, 0, 0, 0));
        res_head = (h + 1) % SLOTS;
        res_fill--;
    endfunction

    function automatic bit locate_hole(int sz, output int b);
        int run, pos, start, len, bl, bb;
        bit found, take;
        b = 0;
        if (pol_q == cfa_pkg::POL_NEXT) begin
            run = 0;
            for (int k = 0; k < 2 * UNITS; k++) begin
                pos = (k < UNITS - next_pos) ? next_pos + k : (k - (UNITS - next_pos)) % UNITS;
                if (pos == 0) run = 0;
                if (busy_map[pos]) run = 0;
                else run++;
                if (run >= sz) begin
                    b = pos + 1 - sz;
                    return 1;
                end
            end
            return 0;
        end
        start = 0; len = 0; bl = 0; bb = 0; found = 0;
        for (int i = 0; i <= UNITS; i++) begin
            if (i < UNITS && !busy_map[i]) begin
                if (len == 0) start = i;
                len++;
            end else begin
                if (len >= sz) begin
                    if (pol_q == cfa_pkg::POL_FIRST) take = !found;
                    else if (pol_q == cfa_pkg::POL_BEST) take = !found || len <= bl;
                    else take = !found || len > bl;
                    if (take) begin
                        found = 1; bl = len; bb = start;
                    end
                end
                len = 0;
            end
        end
        b = bb;
        return found;
    endfunction

    // Works out the results of one accepted request into scratch_q.
    function automatic void predict_request(logic func, logic [7:0] id, logic [7:0] size,
                                            logic [3:0] sw);
        int b, used, holes, slot;
        scratch_q.delete();
        if (func == cfa_pkg::FUNC_CLEAR) begin
            foreach (busy_map[i]) busy_map[i] = 0;
            res_head = 0; res_fill = 0; next_pos = 0;
            scratch_q.push_back(mk(cfa_pkg::KIND_CLEARED, 8'h00, 0, 0, 0, 0, 0, 0, 1));
            return;
        end
        if (size == 0 || size > UNITS) begin
            scratch_q.push_back(mk(cfa_pkg::KIND_REJECTED, id, 0, 0, 0, 0, 0, 0, 1));
            return;
        end
        if (res_fill >= SLOTS) evict_oldest();
        for (int t = 0; t <= SLOTS; t++) begin
            if (locate_hole(size, b)) break;
            if (res_fill == 0) break;
            evict_oldest();
        end
        for (int i = 0; i < size; i++) busy_map[(b + i) % UNITS] = 1;
        slot = (res_head + res_fill) % SLOTS;
        res_id[slot] = id; res_base[slot] = b; res_size[slot] = size; res_sw[slot] = sw;
        res_fill++;
        next_pos = (b + size) % UNITS;
        used = 0; holes = 0;
        for (int i = 0; i < UNITS; i++) begin
            if (busy_map[i]) used++;
            else if (i == 0 || busy_map[i - 1]) holes++;
        end
        scratch_q.push_back(mk(cfa_pkg::KIND_LOADED, id, b, 0, 0, res_fill, holes, used, 1));
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Long receiver hold-off, counted down here.
    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Result side: checks every transfer and drives m_ready.
    always @(posedge aclk) begin
        outcome_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            if (aresetn && m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    $error("result transfer with no expectation, kind %0d", m_kind);
                    errors++;
                end else begin
                    e = pending_q.pop_front();
                    check_field("kind", e.kind, m_kind);
                    check_field("out_id", e.id, m_out_id);
                    check_field("base_unit", e.base, m_base_unit);
                    check_field("new_swaps", e.nsw, m_new_swaps);
                    check_field("requeue", e.rq, m_requeue);
                    check_field("resident_count", e.rc, m_resident_count);
                    check_field("hole_count", e.hc, m_hole_count);
                    check_field("used_units", e.used, m_used_units);
                    check_field("last", e.last, m_last);
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        while (pending_q.size() != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == cfa_pkg::REG_POLICY) pol_q = val[1:0];
        else limit_q = val;
    endtask

    // Offers one request and returns at the edge where it is transferred.
    task automatic offer(logic func, logic [7:0] id, logic [7:0] size, logic [3:0] sw);
        if ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_proc_id <= id;
        s_req_size <= size;
        s_swap_count <= sw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(func, id, size, sw);
    endtask

    row_t dir_rows[] = '{
        '{cfa_pkg::FUNC_ALLOC, 8'hFF, 8'd128, 4'd15, 1'b1, cfa_pkg::KIND_LOADED,
          7'd0, 6'd1, 7'd0, 8'd128},
        '{cfa_pkg::FUNC_ALLOC, 8'h00, 8'd0, 4'd0, 1'b1, cfa_pkg::KIND_REJECTED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'hA5, 8'd129, 4'd0, 1'b1, cfa_pkg::KIND_REJECTED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h5A, 8'd255, 4'd0, 1'b1, cfa_pkg::KIND_REJECTED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h01, 8'd1, 4'd15, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_CLEAR, 8'h00, 8'd0, 4'd0, 1'b1, cfa_pkg::KIND_CLEARED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h02, 8'd127, 4'd0, 1'b1, cfa_pkg::KIND_LOADED,
          7'd0, 6'd1, 7'd1, 8'd127},
        '{cfa_pkg::FUNC_ALLOC, 8'h03, 8'd1, 4'd2, 1'b1, cfa_pkg::KIND_LOADED,
          7'd127, 6'd2, 7'd0, 8'd128},
        '{cfa_pkg::FUNC_ALLOC, 8'h04, 8'd64, 4'd1, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h05, 8'd16, 4'd14, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h06, 8'd32, 4'd7, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h07, 8'd8, 4'd0, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h08, 8'd2, 4'd0, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h09, 8'd100, 4'd3, 1'b0, cfa_pkg::KIND_LOADED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_CLEAR, 8'h00, 8'd0, 4'd0, 1'b1, cfa_pkg::KIND_CLEARED,
          7'd0, 6'd0, 7'd0, 8'd0},
        '{cfa_pkg::FUNC_ALLOC, 8'h80, 8'd64, 4'd8, 1'b1, cfa_pkg::KIND_LOADED,
          7'd0, 6'd1, 7'd1, 8'd64},
        '{cfa_pkg::FUNC_ALLOC, 8'h7F, 8'd64, 4'd0, 1'b1, cfa_pkg::KIND_LOADED,
          7'd64, 6'd2, 7'd0, 8'd128}
    };

    logic [1:0] phase_pol [6] = '{cfa_pkg::POL_FIRST, cfa_pkg::POL_BEST, cfa_pkg::POL_WORST,
                                  cfa_pkg::POL_NEXT, cfa_pkg::POL_NEXT, cfa_pkg::POL_FIRST};
    logic [3:0] phase_lim [6] = '{4'd3, 4'd0, 4'd15, 4'd7, 4'd1, 4'd15};
    int phase_send [6] = '{0, 49, 0, 21, 0, 49};
    int phase_recv [6] = '{0, 0, 49, 21, 0, 49};
    int phase_items [6] = '{15, 15, 15, 15, 20, 15};

    initial begin
        logic func;
        logic [7:0] size;
        int pick;
        foreach (busy_map[i]) busy_map[i] = 0;
        res_head = 0; res_fill = 0; next_pos = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            offer(dir_rows[r].func, dir_rows[r].id, dir_rows[r].size, dir_rows[r].sw);
            if (dir_rows[r].typed)
                pending_q.push_back(mk(dir_rows[r].kind,
                                       dir_rows[r].func == cfa_pkg::FUNC_CLEAR ? 8'h00
                                                                             : dir_rows[r].id,
                                       dir_rows[r].base, 0, 0, dir_rows[r].rc,
                                       dir_rows[r].hc, dir_rows[r].used, 1));
            else
                foreach (scratch_q[j]) pending_q.push_back(scratch_q[j]);
        end

        for (int p = 0; p < 6; p++) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            write_reg(cfa_pkg::REG_POLICY, {2'b00, phase_pol[p]});
            write_reg(cfa_pkg::REG_LIMIT, phase_lim[p]);
            send_pct = phase_send[p];
            recv_pct = phase_recv[p];
            // The fill phase keeps the sender busy behind a long receiver hold-off.
            if (p == 4) hold_left = 4000;
            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(99);
                func = cfa_pkg::FUNC_ALLOC;
                if (p == 4) size = 8'($urandom_range(1, 3));
                else if (pick < 4) func = cfa_pkg::FUNC_CLEAR;
                if (p != 4) begin
                    if (pick < 8) size = ($urandom_range(1) != 0) ? 8'd0
                                                                 : 8'($urandom_range(129, 255));
                    else if (pick < 20) size = 8'($urandom_range(33, 128));
                    else size = 8'($urandom_range(1, 16));
                end
                offer(func, 8'($urandom_range(255)), size, 4'($urandom_range(15)));
                foreach (scratch_q[j]) pending_q.push_back(scratch_q[j]);
            end
        end

        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4 * UNITS) @(posedge aclk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
